// ===== sv/lz_command_stream_decompressor_defines.svh =====
// Assertion macros shared by the decompressor RTL.
`ifndef LZ_COMMAND_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZ_COMMAND_STREAM_DECOMPRESSOR_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define LZCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked at every rising clock edge outside reset.
`define LZCS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

// ===== sv/lzcs_pkg.sv =====
// Types, codes and helper functions of the LZ command stream decompressor.
`timescale 1ns / 1ps
package lzcs_pkg;

    localparam int HISTORY_DEPTH_DEF = 32768;
    localparam int BEAT_BYTES_DEF    = 16;
    // Width used for all position and limit compares.
    localparam int CMP_W             = 18;
    localparam int CNT_W             = 11;
    localparam int CAP_RESET         = 32768;

    localparam logic [7:0] END_MARK  = 8'hFF;

    // Command codes (top three bits of a command byte).
    localparam logic [2:0] CMD_LIT   = 3'd0;
    localparam logic [2:0] CMD_FILL  = 3'd1;
    localparam logic [2:0] CMD_PAIR  = 3'd2;
    localparam logic [2:0] CMD_ZERO  = 3'd3;
    localparam logic [2:0] CMD_FWD   = 3'd4;
    localparam logic [2:0] CMD_REV   = 3'd5;
    localparam logic [2:0] CMD_BACK  = 3'd6;
    localparam logic [2:0] CMD_LONG  = 3'd7;

    // Stream status codes.
    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_BIG    = 3'd2;
    localparam logic [2:0] ST_BADCMD = 3'd3;
    localparam logic [2:0] ST_BADREF = 3'd4;

    typedef enum logic [2:0] {
        PH_CMD, PH_LONGLEN, PH_LIT, PH_FILL, PH_PAIR1, PH_PAIR2, PH_OFS1, PH_OFS2
    } t_phase;

    typedef enum logic [1:0] {
        RK_FILL, RK_PAIR, RK_COPY
    } t_run;

    typedef enum logic [1:0] {
        S_IDLE, S_GEN, S_RD, S_FLUSH
    } t_eng_state;

    function automatic logic [7:0] bit_rev(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

endpackage

// ===== sv/lz_command_stream_decompressor.sv =====
// Top level of the LZ command stream decompressor: parser, history memory, beat packer.
`timescale 1ns / 1ps
// Usage:
// The slave channel takes one compressed byte per request in i_s_tdata[7:0];
// i_s_tuser[0] marks the first byte of a stream and clears length and parser
// state before that byte is handled. The master channel returns beats of up
// to sixteen output bytes with byte count, stream status and total length;
// o_m_tlast marks the final beat caused by an input byte. A byte that yields
// no output gives one status-only beat (byte count zero).
// Sequencing: a header byte is decoded and then handed off as a beat.
// Fill, pair and literal bytes then generate their output bytes in turn;
// copy bytes issue a history read for each output byte and wait on the
// registered memory read before the byte is written back. A full beat is
// handed off before generation goes on. The next input is taken once the
// previous final beat sits in the output register.
// Reset clears the parser, the write position, status and the capacity
// register (to 32768). History contents are not cleared; no valid reads
// depend on them. When the receiver stalls, the output register holds its
// beat and byte generation pauses once the next beat is full.
// Configuration writes (i_cfg_wen) are legal only while the block is idle.
module lz_command_stream_decompressor
    import lzcs_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int BEAT_BYTES    = BEAT_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Slave stream.
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,  // comp_byte
    input  logic [0:0]                 i_s_tuser,  // first_of_stream
    // Master stream.
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // out_bytes_low, out_bytes_high, byte_count, status, total_length
    output logic [BEAT_BYTES*8+23:0]   o_m_tdata,
    output logic                       o_m_tlast,  // last_of_item
    // Configuration.
    input  logic                       i_cfg_wen,
    input  logic [15:0]                i_cfg_wdata
);

    `include "lz_command_stream_decompressor_defines.svh"

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int PW  = $clog2(HISTORY_DEPTH + 1);
    localparam int BCW = $clog2(BEAT_BYTES + 1);
    localparam int BIW = $clog2(BEAT_BYTES);

    // History memory.
    logic [7:0]      mem [HISTORY_DEPTH];
    logic [7:0]      r_rdata;
    logic            mem_we;
    logic            mem_re;
    logic [7:0]      mem_wdata;

    // Parser state.
    logic [PW-1:0]   r_wp;
    t_phase          r_phase;
    logic [2:0]      r_cmd;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]     r_org;
    logic [7:0]      r_pair;
    logic            r_halt;
    logic [2:0]      r_stat;
    logic [15:0]     r_cap;

    // Run engine.
    t_eng_state      r_state, n_state;
    logic [CNT_W-1:0] r_rem;
    t_run            r_kind;
    logic [7:0]      r_val, r_val2;
    logic            r_tog;
    logic [15:0]     r_src;
    logic [15:0]     r_tot;
    logic [7:0]      r_beat [BEAT_BYTES];
    logic [BCW-1:0]  r_bcnt;

    // Output register.
    logic            r_ovalid;
    logic [7:0]      r_obytes [BEAT_BYTES];
    logic [BCW-1:0]  r_ocnt;
    logic            r_olast;
    logic [2:0]      r_ostat;
    logic [15:0]     r_otot;

    // Decode results.
    logic            clr, halt_e;
    logic [PW-1:0]   wp_e, limit, room;
    t_phase          ph_e, d_ph;
    logic [2:0]      cmd_e, stat_e, d_cmd, d_stat;
    logic [CNT_W-1:0] cnt_e, d_cnt, d_n, fill_n, copy_n, sum_cnt;
    logic [15:0]     org_e, d_org, c_org;
    logic [7:0]      pair_e, d_pair, d_val, d_val2, b;
    logic            d_halt, fill_big;
    t_run            d_kind;
    logic [CMP_W-1:0] kb, lim2;
    logic            c_bad;
    logic [2:0]      copy_stat;

    // Engine strobes.
    logic            accept, out_free, flush, flush_last, prod;
    logic [7:0]      prod_val;

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign b          = i_s_tdata;
    assign clr        = i_s_tuser[0];

    // Effective limit: smaller of the capacity register and the history depth.
    always_comb begin
        if (CMP_W'(r_cap) < CMP_W'(HISTORY_DEPTH)) begin
            limit = PW'(r_cap);
        end else begin
            limit = PW'(HISTORY_DEPTH);
        end
    end

    // State as seen by this byte, after an optional stream restart.
    always_comb begin
        wp_e   = clr ? '0 : r_wp;
        ph_e   = clr ? PH_CMD : r_phase;
        cmd_e  = clr ? 3'd0 : r_cmd;
        cnt_e  = clr ? '0 : r_cnt;
        org_e  = clr ? '0 : r_org;
        pair_e = clr ? '0 : r_pair;
        halt_e = clr ? 1'b0 : r_halt;
        stat_e = clr ? ST_RUN : r_stat;
        room   = (CMP_W'(limit) > CMP_W'(wp_e)) ? (limit - wp_e) : '0;
    end

    // Run length of fill-like commands, cut at the capacity.
    always_comb begin
        sum_cnt  = cnt_e + CNT_W'(b) + CNT_W'(1);
        fill_big = CMP_W'(cnt_e) > CMP_W'(room);
        fill_n   = fill_big ? CNT_W'(room) : cnt_e;
    end

    // Copy run: source origin, length and the status it ends with.
    always_comb begin
        if (ph_e == PH_OFS1) begin
            c_org = 16'(wp_e - PW'({1'b0, b[6:0]}) - PW'(1));
        end else begin
            c_org = {org_e[15:8], b};
        end
        c_bad = CMP_W'(c_org) >= CMP_W'(wp_e);
        kb    = CMP_W'(c_org) + CMP_W'(1);
        if ((cmd_e == CMD_BACK) && (kb < CMP_W'(room))) begin
            lim2 = kb;
        end else begin
            lim2 = CMP_W'(room);
        end
        if (c_bad) begin
            copy_n    = '0;
            copy_stat = ST_BADREF;
        end else if (CMP_W'(cnt_e) > lim2) begin
            copy_n    = CNT_W'(lim2);
            copy_stat = ((cmd_e == CMD_BACK) && (lim2 == kb)) ? ST_BADREF : ST_BIG;
        end else begin
            copy_n    = cnt_e;
            copy_stat = ST_RUN;
        end
    end

    // Byte decode: next parser state and the run this byte starts.
    always_comb begin
        d_ph   = ph_e;
        d_cmd  = cmd_e;
        d_cnt  = cnt_e;
        d_org  = org_e;
        d_pair = pair_e;
        d_halt = halt_e;
        d_stat = stat_e;
        d_n    = '0;
        d_kind = RK_FILL;
        d_val  = b;
        d_val2 = b;
        if (!halt_e) begin
            case (ph_e)
                PH_CMD: begin
                    if (b == END_MARK) begin
                        d_halt = 1'b1;
                        d_stat = ST_DONE;
                    end else if (room == '0) begin
                        d_halt = 1'b1;
                        d_stat = ST_BIG;
                    end else if (b[7:5] == CMD_LONG) begin
                        d_cmd = b[4:2];
                        if (b[4:2] == CMD_LONG) begin
                            d_halt = 1'b1;
                            d_stat = ST_BADCMD;
                        end else begin
                            d_cnt = CNT_W'({b[1:0], 8'h00});
                            d_ph  = PH_LONGLEN;
                        end
                    end else begin
                        d_cmd = b[7:5];
                        d_cnt = CNT_W'(b[4:0]) + CNT_W'(1);
                        case (b[7:5])
                            CMD_LIT:  d_ph = PH_LIT;
                            CMD_FILL: d_ph = PH_FILL;
                            CMD_PAIR: d_ph = PH_PAIR1;
                            CMD_ZERO: begin
                                // Zero fill runs at once; length is bounded by the capacity.
                                d_ph = PH_CMD;
                                d_val = 8'h00;
                                if (CMP_W'(d_cnt) > CMP_W'(room)) begin
                                    d_n    = CNT_W'(room);
                                    d_halt = 1'b1;
                                    d_stat = ST_BIG;
                                end else begin
                                    d_n = d_cnt;
                                end
                            end
                            default:  d_ph = PH_OFS1;
                        endcase
                    end
                end
                PH_LONGLEN: begin
                    d_cnt = sum_cnt;
                    case (cmd_e)
                        CMD_LIT:  d_ph = PH_LIT;
                        CMD_FILL: d_ph = PH_FILL;
                        CMD_PAIR: d_ph = PH_PAIR1;
                        CMD_ZERO: begin
                            d_ph  = PH_CMD;
                            d_val = 8'h00;
                            if (CMP_W'(sum_cnt) > CMP_W'(room)) begin
                                d_n    = CNT_W'(room);
                                d_halt = 1'b1;
                                d_stat = ST_BIG;
                            end else begin
                                d_n = sum_cnt;
                            end
                        end
                        default:  d_ph = PH_OFS1;
                    endcase
                end
                PH_LIT: begin
                    if (room == '0) begin
                        d_halt = 1'b1;
                        d_stat = ST_BIG;
                    end else begin
                        d_n = CNT_W'(1);
                    end
                    if (cnt_e != '0) begin
                        d_cnt = cnt_e - CNT_W'(1);
                    end
                    if ((cnt_e == '0) || (cnt_e == CNT_W'(1))) begin
                        d_ph = PH_CMD;
                    end
                end
                PH_FILL, PH_PAIR2: begin
                    d_ph   = PH_CMD;
                    d_n    = fill_n;
                    d_kind = (ph_e == PH_PAIR2) ? RK_PAIR : RK_FILL;
                    if (ph_e == PH_PAIR2) begin
                        d_val = pair_e;
                    end
                    if (fill_big) begin
                        d_halt = 1'b1;
                        d_stat = ST_BIG;
                    end
                end
                PH_PAIR1: begin
                    d_pair = b;
                    d_ph   = PH_PAIR2;
                end
                default: begin
                    // Offset bytes: relative offset, absolute high byte or low byte.
                    d_ph = PH_CMD;
                    if ((ph_e == PH_OFS1) && !b[7]) begin
                        d_org = {b, 8'h00};
                        d_ph  = PH_OFS2;
                    end else if ((ph_e == PH_OFS1) &&
                                 (CMP_W'({1'b0, b[6:0]}) + CMP_W'(1) > CMP_W'(wp_e))) begin
                        d_halt = 1'b1;
                        d_stat = ST_BADREF;
                    end else begin
                        d_org  = c_org;
                        d_kind = RK_COPY;
                        d_n    = copy_n;
                        if (copy_stat != ST_RUN) begin
                            d_halt = 1'b1;
                            d_stat = copy_stat;
                        end
                    end
                end
            endcase
        end
    end

    // Engine next state and strobes.
    always_comb begin
        n_state    = r_state;
        flush      = 1'b0;
        flush_last = 1'b0;
        prod       = 1'b0;
        mem_re     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (d_n == '0) ? S_FLUSH : S_GEN;
                end
            end
            S_GEN: begin
                if (r_bcnt == BCW'(BEAT_BYTES)) begin
                    flush = out_free;
                end else if (r_kind == RK_COPY) begin
                    mem_re  = 1'b1;
                    n_state = S_RD;
                end else begin
                    prod = 1'b1;
                    if (r_rem == CNT_W'(1)) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_RD: begin
                prod    = 1'b1;
                n_state = (r_rem == CNT_W'(1)) ? S_FLUSH : S_GEN;
            end
            S_FLUSH: begin
                if (out_free) begin
                    flush      = 1'b1;
                    flush_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Byte value of the current output byte.
    always_comb begin
        if (r_state == S_RD) begin
            prod_val = (r_cmd == CMD_REV) ? bit_rev(r_rdata) : r_rdata;
        end else if ((r_kind == RK_PAIR) && r_tog) begin
            prod_val = r_val2;
        end else begin
            prod_val = r_val;
        end
    end

    assign mem_we    = prod;
    assign mem_wdata = prod_val;

    // History memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp[AW-1:0]] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[r_src[AW-1:0]];
        end
    end

    // Engine state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Parser registers, write position and capacity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_phase <= PH_CMD;
            r_cmd   <= '0;
            r_cnt   <= '0;
            r_org   <= '0;
            r_pair  <= '0;
            r_halt  <= 1'b0;
            r_stat  <= ST_RUN;
            r_cap   <= 16'(CAP_RESET);
        end else begin
            if (i_cfg_wen) begin
                r_cap <= i_cfg_wdata;
            end
            if (accept) begin
                r_wp    <= wp_e;
                r_phase <= d_ph;
                r_cmd   <= d_cmd;
                r_cnt   <= d_cnt;
                r_org   <= d_org;
                r_pair  <= d_pair;
                r_halt  <= d_halt;
                r_stat  <= d_stat;
            end else if (prod) begin
                r_wp <= r_wp + PW'(1);
            end
        end
    end

    // Run registers and beat packing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
        end else if (accept) begin
            r_rem  <= d_n;
            r_kind <= d_kind;
            r_val  <= d_val;
            r_val2 <= d_val2;
            r_tog  <= 1'b0;
            r_src  <= d_org;
            r_tot  <= 16'(wp_e + PW'(d_n));
            r_bcnt <= '0;
            for (int i = 0; i < BEAT_BYTES; i++) begin
                r_beat[i] <= 8'h00;
            end
        end else begin
            if (mem_re) begin
                r_src <= (r_cmd == CMD_BACK) ? (r_src - 16'd1) : (r_src + 16'd1);
            end
            if (flush) begin
                r_bcnt <= '0;
                for (int i = 0; i < BEAT_BYTES; i++) begin
                    r_beat[i] <= 8'h00;
                end
            end else if (prod) begin
                r_beat[r_bcnt[BIW-1:0]] <= prod_val;
                r_bcnt <= r_bcnt + BCW'(1);
                r_rem  <= r_rem - CNT_W'(1);
                r_tog  <= !r_tog;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (flush) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (flush) begin
            r_obytes <= r_beat;
            r_ocnt   <= r_bcnt;
            r_olast  <= flush_last;
            r_ostat  <= r_stat;
            r_otot   <= r_tot;
        end
    end

    // Output packing.
    always_comb begin
        o_m_tdata = '0;
        for (int i = 0; i < BEAT_BYTES; i++) begin
            o_m_tdata[8*i +: 8] = r_obytes[i];
        end
        o_m_tdata[8*BEAT_BYTES +: 5]  = 5'(r_ocnt);
        o_m_tdata[8*BEAT_BYTES+5 +: 3] = r_ostat;
        o_m_tdata[8*BEAT_BYTES+8 +: 16] = r_otot;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_olast;

    // A copy read never reaches a position at or beyond the write position.
    `LZCS_ASSERT_IMP(a_read_below_wp, mem_re, CMP_W'(r_src) < CMP_W'(r_wp), "copy read past write position")
    // History writes stay inside the memory.
    `LZCS_ASSERT_IMP(a_write_in_depth, mem_we, CMP_W'(r_wp) < CMP_W'(HISTORY_DEPTH), "history write beyond depth")
    // A status-only beat is always the final beat of its byte.
    `LZCS_ASSERT_IMP(a_empty_is_last, o_m_tvalid && (r_ocnt == '0), o_m_tlast, "status-only beat not last")
    // The generator only runs with bytes still to produce.
    `LZCS_ASSERT_ALWAYS(a_gen_has_work, (r_state != S_GEN && r_state != S_RD) || (r_rem != '0), "run with no bytes left")

endmodule
